// ===== rtl/foot_center_of_pressure_unit_defines.svh =====
// Assertion macros shared by the center of pressure RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef FOOT_CENTER_OF_PRESSURE_UNIT_DEFINES_SVH
`define FOOT_CENTER_OF_PRESSURE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define COP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define COP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cop_pkg.sv =====
// Shared types and constants for the foot center of pressure unit.
// No dependencies; imported by the channel interfaces and all modules.
package cop_pkg;

    localparam int NUM_CORNERS = 4;
    localparam int FORCE_W     = 16;
    localparam int COORD_W     = 16;
    localparam int POS_W       = 32;
    localparam int TOTAL_W     = 18;
    localparam int CFG_IDX_W   = 3;
    // signed coordinate times zero-extended force
    localparam int PROD_W      = COORD_W + FORCE_W + 1;
    // sum of four products
    localparam int WSUM_W      = PROD_W + 2;
    // magnitude of the weighted sum
    localparam int MAG_W       = WSUM_W - 1;
    // one quotient bit per division cell
    localparam int NUM_CELLS   = COORD_W;
    localparam int DIV_SHIFT   = NUM_CELLS - 1;
    localparam logic [TOTAL_W-1:0] THRESHOLD_RESET = TOTAL_W'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CORNER0   = 3'd0,
        CFG_CORNER1   = 3'd1,
        CFG_CORNER2   = 3'd2,
        CFG_CORNER3   = 3'd3,
        CFG_THRESHOLD = 3'd4
    } t_cfg_index;

    // Per-item control that rides along the pipeline
    typedef struct packed {
        logic               contact;
        logic [TOTAL_W-1:0] total;
        logic               do_div;
        logic               neg_x;
        logic               neg_y;
    } t_cop_tag;

    // Payload of one division cell
    typedef struct packed {
        t_cop_tag           tag;
        logic [MAG_W-1:0]   rem_x;
        logic [MAG_W-1:0]   rem_y;
        logic [COORD_W-1:0] quo_x;
        logic [COORD_W-1:0] quo_y;
    } t_cop_div;

endpackage

// ===== rtl/cop_if.sv =====
// Valid/ready channels for force items in and center of pressure items out.
// Depends on cop_pkg for field widths.
interface cop_in_if import cop_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FORCE_W-1:0] force_corner0;
    logic [FORCE_W-1:0] force_corner1;
    logic [FORCE_W-1:0] force_corner2;
    logic [FORCE_W-1:0] force_corner3;

    modport source (output valid, force_corner0, force_corner1, force_corner2,
                    force_corner3, input ready);
    modport sink   (input valid, force_corner0, force_corner1, force_corner2,
                    force_corner3, output ready);
endinterface

interface cop_out_if import cop_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      in_contact;
    logic [TOTAL_W-1:0]        total_force;
    logic signed [COORD_W-1:0] pressure_x;
    logic signed [COORD_W-1:0] pressure_y;

    modport source (output valid, in_contact, total_force, pressure_x, pressure_y,
                    input ready);
    modport sink   (input valid, in_contact, total_force, pressure_x, pressure_y,
                    output ready);
endinterface

// ===== rtl/cop_front.sv =====
// Front end: total force, contact test, weighted coordinate sums, sign/magnitude.
// Depends on cop_pkg; feeds the first division cell.
module cop_front import cop_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  logic [FORCE_W-1:0] i_force [NUM_CORNERS],
    input  logic [POS_W-1:0]   i_pos [NUM_CORNERS],
    input  logic [TOTAL_W-1:0] i_threshold,
    output logic               o_valid,
    output t_cop_div           o_stage
);

    // stage A: products and total
    logic                     r_a_valid;
    t_cop_tag                 r_a_tag;
    logic signed [PROD_W-1:0] r_px [NUM_CORNERS];
    logic signed [PROD_W-1:0] r_py [NUM_CORNERS];
    t_cop_tag                 n_a_tag;
    logic signed [PROD_W-1:0] n_px [NUM_CORNERS];
    logic signed [PROD_W-1:0] n_py [NUM_CORNERS];

    // stage B: weighted sums
    logic                     r_b_valid;
    t_cop_tag                 r_b_tag;
    logic signed [WSUM_W-1:0] r_sx;
    logic signed [WSUM_W-1:0] r_sy;
    t_cop_tag                 n_b_tag;
    logic signed [WSUM_W-1:0] n_sx;
    logic signed [WSUM_W-1:0] n_sy;

    // stage C: sign and magnitude
    logic                     r_c_valid;
    t_cop_div                 r_c_stage;
    t_cop_div                 n_c_stage;

    // Multiply each corner coordinate by its force, add up the forces
    always_comb begin
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [TOTAL_W-1:0]        sum;
        sum = '0;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            cx      = $signed(i_pos[i][POS_W-1:COORD_W]);
            cy      = $signed(i_pos[i][COORD_W-1:0]);
            n_px[i] = PROD_W'(cx * $signed({1'b0, i_force[i]}));
            n_py[i] = PROD_W'(cy * $signed({1'b0, i_force[i]}));
            sum     = sum + TOTAL_W'(i_force[i]);
        end
        n_a_tag         = '0;
        n_a_tag.total   = sum;
        n_a_tag.contact = (sum >= i_threshold);
    end

    // Add the four products per axis; decide whether a quotient is needed
    always_comb begin
        n_sx = '0;
        n_sy = '0;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            n_sx = n_sx + WSUM_W'(r_px[i]);
            n_sy = n_sy + WSUM_W'(r_py[i]);
        end
        n_b_tag        = r_a_tag;
        n_b_tag.do_div = r_a_tag.contact && (r_a_tag.total != '0);
    end

    // Split each sum into sign and magnitude for the unsigned divider
    always_comb begin
        n_c_stage           = '0;
        n_c_stage.tag       = r_b_tag;
        n_c_stage.tag.neg_x = r_sx[WSUM_W-1];
        n_c_stage.tag.neg_y = r_sy[WSUM_W-1];
        n_c_stage.rem_x     = MAG_W'(r_sx[WSUM_W-1] ? -r_sx : r_sx);
        n_c_stage.rem_y     = MAG_W'(r_sy[WSUM_W-1] ? -r_sy : r_sy);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_tag   <= n_a_tag;
            r_px      <= n_px;
            r_py      <= n_py;
            r_b_tag   <= n_b_tag;
            r_sx      <= n_sx;
            r_sy      <= n_sy;
            r_c_stage <= n_c_stage;
        end
    end

    assign o_valid = r_c_valid;
    assign o_stage = r_c_stage;

endmodule

// ===== rtl/cop_div_cell.sv =====
// One restoring-division cell: settles one quotient bit for x and for y.
// Depends on cop_pkg; chained NUM_CELLS deep in the top level.
module cop_div_cell import cop_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  logic     i_valid,
    input  t_cop_div i_stage,
    output logic     o_valid,
    output t_cop_div o_stage
);

    logic             r_valid;
    t_cop_div         r_stage;
    t_cop_div         n_stage;
    logic [MAG_W:0]   w_dshift;
    logic [MAG_W:0]   w_trial_x;
    logic [MAG_W:0]   w_trial_y;
    logic [MAG_W-1:0] w_keep_x;
    logic [MAG_W-1:0] w_keep_y;

    // Trial subtract of the divisor aligned to the top quotient bit
    assign w_dshift  = (MAG_W + 1)'({i_stage.tag.total, DIV_SHIFT'(0)});
    assign w_trial_x = {1'b0, i_stage.rem_x} - w_dshift;
    assign w_trial_y = {1'b0, i_stage.rem_y} - w_dshift;
    assign w_keep_x  = w_trial_x[MAG_W] ? i_stage.rem_x : w_trial_x[MAG_W-1:0];
    assign w_keep_y  = w_trial_y[MAG_W] ? i_stage.rem_y : w_trial_y[MAG_W-1:0];

    // Shift remainder and quotient one place
    always_comb begin
        n_stage       = i_stage;
        n_stage.rem_x = {w_keep_x[MAG_W-2:0], 1'b0};
        n_stage.rem_y = {w_keep_y[MAG_W-2:0], 1'b0};
        n_stage.quo_x = {i_stage.quo_x[COORD_W-2:0], !w_trial_x[MAG_W]};
        n_stage.quo_y = {i_stage.quo_y[COORD_W-2:0], !w_trial_y[MAG_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ===== rtl/foot_center_of_pressure_unit.sv =====
// Pipeline: an accepted item passes through 3 front-end stages, 16 division cells
//   and 1 output register on its way to the output.
// Throughput: one item per cycle; the whole pipeline holds while the output is stalled.
// The division chain settles one quotient bit per cell per cycle while the pipeline advances.
// Reset (synchronous, active low) empties the pipeline, clears corner positions
//   to 0 and sets the contact threshold to 50.
module foot_center_of_pressure_unit import cop_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data,
    cop_in_if.sink               i_in,
    cop_out_if.source            o_out
);

`include "foot_center_of_pressure_unit_defines.svh"

    logic [POS_W-1:0]          r_pos [NUM_CORNERS];
    logic [TOTAL_W-1:0]        r_threshold;
    logic [FORCE_W-1:0]        w_force [NUM_CORNERS];
    logic                      w_adv;
    logic                      w_valid [NUM_CELLS+1];
    t_cop_div                  w_stage [NUM_CELLS+1];
    t_cop_div                  w_last;
    logic                      r_out_valid;
    logic                      r_out_contact;
    logic [TOTAL_W-1:0]        r_out_total;
    logic signed [COORD_W-1:0] r_out_x;
    logic signed [COORD_W-1:0] r_out_y;
    logic signed [COORD_W-1:0] n_out_x;
    logic signed [COORD_W-1:0] n_out_y;

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                r_pos[i] <= '0;
            end
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CORNER0:   r_pos[0]    <= i_cfg_data;
                CFG_CORNER1:   r_pos[1]    <= i_cfg_data;
                CFG_CORNER2:   r_pos[2]    <= i_cfg_data;
                CFG_CORNER3:   r_pos[3]    <= i_cfg_data;
                CFG_THRESHOLD: r_threshold <= i_cfg_data[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance everything unless a finished item is waiting downstream
    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv;

    assign w_force[0] = i_in.force_corner0;
    assign w_force[1] = i_in.force_corner1;
    assign w_force[2] = i_in.force_corner2;
    assign w_force[3] = i_in.force_corner3;

    cop_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (i_in.valid),
        .i_force     (w_force),
        .i_pos       (r_pos),
        .i_threshold (r_threshold),
        .o_valid     (w_valid[0]),
        .o_stage     (w_stage[0])
    );

    // Division chain, one quotient bit per cell, most significant first
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        cop_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_valid[g]),
            .i_stage (w_stage[g]),
            .o_valid (w_valid[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    assign w_last = w_stage[NUM_CELLS];

    // Restore the sign; drop the centroid without contact or with zero force
    always_comb begin
        n_out_x = '0;
        n_out_y = '0;
        if (w_last.tag.do_div) begin
            n_out_x = w_last.tag.neg_x ? -$signed(w_last.quo_x) : $signed(w_last.quo_x);
            n_out_y = w_last.tag.neg_y ? -$signed(w_last.quo_y) : $signed(w_last.quo_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_contact <= w_last.tag.contact;
            r_out_total   <= w_last.tag.total;
            r_out_x       <= n_out_x;
            r_out_y       <= n_out_y;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.in_contact  = r_out_contact;
    assign o_out.total_force = r_out_total;
    assign o_out.pressure_x  = r_out_x;
    assign o_out.pressure_y  = r_out_y;

    // Contact flag agrees with the delivered total and the threshold
    `COP_ASSERT_NOW(a_contact_matches, i_clk, i_rst_n, r_out_valid, r_out_contact == (r_out_total >= r_threshold), "contact flag disagrees with total force")
    // No contact means a zero centroid
    `COP_ASSERT_NOW(a_zero_without_contact, i_clk, i_rst_n, r_out_valid && !r_out_contact, r_out_x == '0 && r_out_y == '0, "centroid nonzero without contact")
    // A weighted mean never needs more than a 0x8000 quotient magnitude
    `COP_ASSERT_NOW(a_quotient_bound, i_clk, i_rst_n, w_valid[NUM_CELLS] && w_last.tag.do_div, w_last.quo_x <= 16'h8000 && w_last.quo_y <= 16'h8000, "quotient out of range")
    // A stall freezes the division chain
    `COP_ASSERT_NEXT(a_chain_holds, i_clk, i_rst_n, !w_adv, $stable(w_valid[NUM_CELLS]) && $stable(w_last), "division chain moved during stall")

endmodule
